>>> hdl/bmp_stream_pixel_decoder_defines.svh
// ----------------------------------------------------------------------------
// BMP stream decoder assertion macros
// Concurrent check wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BMP_STREAM_PIXEL_DECODER_DEFINES_SVH
`define BMP_STREAM_PIXEL_DECODER_DEFINES_SVH

`ifndef SYNTH
`define BSPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BSPD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSPD_ASSERT(lbl, prop, msg)
`define BSPD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> hdl/bspd_pkg.sv
// ----------------------------------------------------------------------------
// BMP stream decoder package
// Shared constants, status codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package bspd_pkg;

	localparam int MAX_DIM      = 8192;
	localparam int DIM_W        = $clog2(MAX_DIM + 1);
	localparam int RB_W         = DIM_W + 2;
	localparam int DS_W         = RB_W + DIM_W;
	localparam int HEADER_BYTES = 70;
	localparam int BASIC_BYTES  = 54;
	localparam int LEN_W        = 28;
	localparam logic [LEN_W-1:0] POS_MAX = 28'hFFF_FFFF;

	localparam int OFS_DSTART = 10;
	localparam int OFS_ISIZE  = 14;
	localparam int OFS_WIDTH  = 18;
	localparam int OFS_HEIGHT = 22;
	localparam int OFS_PLANES = 26;
	localparam int OFS_BPP    = 28;
	localparam int OFS_COMP   = 30;
	localparam int OFS_MASK   = 54;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_BODY   = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;

	localparam logic [4:0] ST_OK       = 5'd0;
	localparam logic [4:0] ST_LEN      = 5'd1;
	localparam logic [4:0] ST_SIG      = 5'd2;
	localparam logic [4:0] ST_ISIZE    = 5'd3;
	localparam logic [4:0] ST_DIM_BIG  = 5'd4;
	localparam logic [4:0] ST_DIM_ZERO = 5'd5;
	localparam logic [4:0] ST_PLANES   = 5'd6;
	localparam logic [4:0] ST_BPP      = 5'd7;
	localparam logic [4:0] ST_RANGE    = 5'd8;
	localparam logic [4:0] ST_COMP     = 5'd9;
	localparam logic [4:0] ST_COMP24   = 5'd10;
	localparam logic [4:0] ST_COMP32   = 5'd11;
	localparam logic [4:0] ST_LEN_BF   = 5'd12;
	localparam logic [4:0] ST_MASK_R   = 5'd13;
	localparam logic [4:0] ST_INSIDE   = 5'd17;
	localparam logic [4:0] ST_SHORT    = 5'd18;

	localparam logic [31:0] COMP_RGB = 32'd0;
	localparam logic [31:0] COMP_BF  = 32'd3;

	typedef struct packed {
		logic accept;
		logic chk1;
		logic chk2;
		logic chk3;
		logic chkm;
		logic load_stat;
	} ctl_cmd_t;

	typedef struct packed {
		logic at_basic;
		logic at_mask;
		logic out_busy;
	} dp_sts_t;

	// byte lane of a 32-bit header field, hit when the position falls inside it
	function automatic logic lane_hit(input logic [6:0] p, input int base);
		logic [6:0] off;
		off = p - 7'(base);
		return off < 7'd4;
	endfunction

	function automatic logic [1:0] lane(input logic [6:0] p, input int base);
		logic [6:0] off;
		off = p - 7'(base);
		return off[1:0];
	endfunction

	// {ok, nonzero, byte index}
	function automatic logic [3:0] mask_sel(input logic [31:0] m);
		logic [3:0] r;
		case (m)
			32'hFF00_0000: r = 4'b1111;
			32'h00FF_0000: r = 4'b1110;
			32'h0000_FF00: r = 4'b1101;
			32'h0000_00FF: r = 4'b1100;
			32'h0000_0000: r = 4'b1000;
			default:       r = 4'b0000;
		endcase
		return r;
	endfunction

endpackage

>>> hdl/bspd_datapath.sv
// ----------------------------------------------------------------------------
// BMP stream decoder datapath
// Header field capture, header checks, pixel assembly and the result register.
// ----------------------------------------------------------------------------
`include "bmp_stream_pixel_decoder_defines.svh"

module bspd_datapath import bspd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_cmd_t         cmd,
	output dp_sts_t          sts,
	input  logic [7:0]       file_byte,
	input  logic             cfg_wr_en,
	input  logic [LEN_W-1:0] cfg_wr_data,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             is_pixel,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic [7:0]       alpha,
	output logic [4:0]       status,
	output logic             final_res
);

	logic [LEN_W-1:0] flen_q;
	logic [LEN_W-1:0] pos_q;
	logic [1:0]       phase_q;
	logic [4:0]       err_q;
	logic [7:0]       sig0_q, sig1_q;
	logic [31:0]      dstart_q, isize_q, width_q, height_q, comp_q;
	logic [15:0]      planes_q, bpp_q;
	logic [31:0]      mask_q [4];
	logic [2:0]       msel_q [4];
	logic [4:0]       e1_q;
	logic [RB_W-1:0]  rb_q, wb_q, rbc_q;
	logic             bp4_q;
	logic [DS_W-1:0]  dsize_q;
	logic [DIM_W-1:0] row_q;
	logic [1:0]       sub_q;
	logic [7:0]       asm_q [3];
	logic             vld_q;

	logic [6:0]       p7;
	logic             hdr_wr;
	logic [6:0]       moff;
	logic [DIM_W-1:0] w14, h14;
	logic             bp4_c;
	logic [DIM_W+4:0] bw;
	logic [DIM_W+5:0] bw_sum;
	logic [RB_W-1:0]  rb_c, wb_c;
	logic [4:0]       e1_c, code3, codem;
	logic [32:0]      end_sum;
	logic             err8;
	logic [3:0]       ms [4];
	logic             body_hit, active, made;
	logic [1:0]       sub_last;
	logic [RB_W-1:0]  k_next;
	logic [DIM_W-1:0] row_next;
	logic [31:0]      pix;
	logic [7:0]       ch [4];
	logic [7:0]       r_c, g_c, b_c, a_c;
	logic [4:0]       stat_c;
	logic             taken;

	assign p7     = pos_q[6:0];
	assign hdr_wr = cmd.accept && phase_q == PH_HEADER && pos_q < LEN_W'(HEADER_BYTES);
	assign moff   = p7 - 7'(OFS_MASK);

	assign sts.at_basic = phase_q == PH_HEADER && pos_q == LEN_W'(BASIC_BYTES - 1);
	assign sts.at_mask  = phase_q == PH_HEADER && pos_q == LEN_W'(HEADER_BYTES - 1);
	assign sts.out_busy = vld_q && out_stall;

	// basic checks and row geometry
	assign w14    = width_q[DIM_W-1:0];
	assign h14    = height_q[DIM_W-1:0];
	assign bp4_c  = bpp_q == 16'd32;
	assign bw     = bp4_c ? {w14, 5'b0} : ({1'b0, w14, 4'b0} + {2'b0, w14, 3'b0});
	assign bw_sum = {1'b0, bw} + (DIM_W + 6)'(31);
	assign rb_c   = RB_W'({bw_sum[DIM_W+5:5], 2'b00});
	assign wb_c   = bp4_c ? {w14, 2'b00} : ({1'b0, w14, 1'b0} + {2'b0, w14});

	always_comb begin
		if (flen_q < LEN_W'(BASIC_BYTES))
			e1_c = ST_LEN;
		else if (sig0_q != 8'h42 || sig1_q != 8'h4D)
			e1_c = ST_SIG;
		else if (isize_q < 32'd40)
			e1_c = ST_ISIZE;
		else if (width_q > 32'(MAX_DIM) || height_q > 32'(MAX_DIM))
			e1_c = ST_DIM_BIG;
		else if (width_q == 32'd0 || height_q == 32'd0)
			e1_c = ST_DIM_ZERO;
		else if (planes_q != 16'd1)
			e1_c = ST_PLANES;
		else if (bpp_q != 16'd24 && bpp_q != 16'd32)
			e1_c = ST_BPP;
		else
			e1_c = ST_OK;
	end

	assign end_sum = {1'b0, dstart_q} + 33'(dsize_q);
	assign err8    = end_sum >= 33'h0_FFFF_FFFF || end_sum > 33'(flen_q);

	always_comb begin
		if (e1_q != ST_OK)
			code3 = e1_q;
		else if (err8)
			code3 = ST_RANGE;
		else if (comp_q != COMP_RGB && comp_q != COMP_BF)
			code3 = ST_COMP;
		else if (!bp4_q && comp_q != COMP_RGB)
			code3 = ST_COMP24;
		else if (bp4_q && comp_q != COMP_BF)
			code3 = ST_COMP32;
		else if (comp_q == COMP_BF && flen_q < LEN_W'(HEADER_BYTES))
			code3 = ST_LEN_BF;
		else if (dstart_q < 32'(BASIC_BYTES) && comp_q != COMP_BF)
			code3 = ST_INSIDE;
		else
			code3 = ST_OK;
	end

	always_comb begin
		for (int i = 0; i < 4; i++)
			ms[i] = mask_sel(mask_q[i]);
		if (!ms[0][3])
			codem = ST_MASK_R;
		else if (!ms[1][3])
			codem = ST_MASK_R + 5'd1;
		else if (!ms[2][3])
			codem = ST_MASK_R + 5'd2;
		else if (!ms[3][3])
			codem = ST_MASK_R + 5'd3;
		else if (dstart_q < 32'(HEADER_BYTES))
			codem = ST_INSIDE;
		else
			codem = ST_OK;
	end

	// pixel body
	assign body_hit = cmd.accept && phase_q == PH_BODY && {4'b0, pos_q} >= dstart_q;
	assign active   = rbc_q < wb_q;
	assign sub_last = bp4_q ? 2'd3 : 2'd2;
	assign made     = active && sub_q == sub_last;
	assign k_next   = rbc_q + RB_W'(1);
	assign row_next = row_q + DIM_W'(1);
	assign pix      = {file_byte, asm_q[2], asm_q[1], asm_q[0]};

	always_comb begin
		for (int i = 0; i < 4; i++)
			ch[i] = msel_q[i][2] ? pix[{msel_q[i][1:0], 3'b000} +: 8] : 8'd0;
		if (!bp4_q) begin
			// red is the byte on the wire this beat
			r_c = file_byte;
			g_c = asm_q[1];
			b_c = asm_q[0];
			a_c = 8'hFF;
		end else if (!msel_q[3][2]) begin
			r_c = ch[0];
			g_c = ch[1];
			b_c = ch[2];
			a_c = 8'hFF;
		end else if (ch[3] == 8'd0) begin
			r_c = 8'd0;
			g_c = 8'd0;
			b_c = 8'd0;
			a_c = 8'd0;
		end else begin
			r_c = ch[0];
			g_c = ch[1];
			b_c = ch[2];
			a_c = ch[3];
		end
	end

	always_comb begin
		if (err_q != ST_OK)
			stat_c = err_q;
		else if (phase_q == PH_HEADER)
			stat_c = (flen_q < LEN_W'(BASIC_BYTES)) ? ST_LEN : ST_SHORT;
		else
			stat_c = (pos_q < flen_q) ? ST_SHORT : ST_OK;
	end

	// header field capture
	always_ff @(posedge clk) begin
		if (hdr_wr) begin
			if (p7 == 7'd0)
				sig0_q <= file_byte;
			if (p7 == 7'd1)
				sig1_q <= file_byte;
			if (lane_hit(p7, OFS_DSTART))
				dstart_q[{lane(p7, OFS_DSTART), 3'b000} +: 8] <= file_byte;
			if (lane_hit(p7, OFS_ISIZE))
				isize_q[{lane(p7, OFS_ISIZE), 3'b000} +: 8] <= file_byte;
			if (lane_hit(p7, OFS_WIDTH))
				width_q[{lane(p7, OFS_WIDTH), 3'b000} +: 8] <= file_byte;
			if (lane_hit(p7, OFS_HEIGHT))
				height_q[{lane(p7, OFS_HEIGHT), 3'b000} +: 8] <= file_byte;
			if (p7 == 7'(OFS_PLANES))
				planes_q[7:0] <= file_byte;
			if (p7 == 7'(OFS_PLANES + 1))
				planes_q[15:8] <= file_byte;
			if (p7 == 7'(OFS_BPP))
				bpp_q[7:0] <= file_byte;
			if (p7 == 7'(OFS_BPP + 1))
				bpp_q[15:8] <= file_byte;
			if (lane_hit(p7, OFS_COMP))
				comp_q[{lane(p7, OFS_COMP), 3'b000} +: 8] <= file_byte;
			if (moff < 7'd16)
				mask_q[moff[3:2]][{moff[1:0], 3'b000} +: 8] <= file_byte;
		end
		if (cmd.chk1) begin
			e1_q  <= e1_c;
			rb_q  <= rb_c;
			wb_q  <= wb_c;
			bp4_q <= bp4_c;
		end
		if (cmd.chk2)
			dsize_q <= rb_q * h14;
		if (cmd.chkm)
			for (int i = 0; i < 4; i++)
				msel_q[i] <= ms[i][2:0];
		if (body_hit && active && sub_q != 2'd3)
			asm_q[sub_q] <= file_byte;
	end

	// decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flen_q  <= '0;
			pos_q   <= '0;
			phase_q <= PH_HEADER;
			err_q   <= ST_OK;
			rbc_q   <= '0;
			row_q   <= '0;
			sub_q   <= '0;
		end else begin
			if (cfg_wr_en)
				flen_q <= cfg_wr_data;
			if (cmd.load_stat) begin
				pos_q   <= '0;
				phase_q <= PH_HEADER;
				err_q   <= ST_OK;
				rbc_q   <= '0;
				row_q   <= '0;
				sub_q   <= '0;
			end
			if (cmd.chk3 && !(code3 == ST_OK && comp_q == COMP_BF)) begin
				err_q   <= code3;
				phase_q <= (code3 != ST_OK) ? PH_DONE : PH_BODY;
			end
			if (cmd.chkm) begin
				err_q   <= codem;
				phase_q <= (codem != ST_OK) ? PH_DONE : PH_BODY;
			end
			if (cmd.accept && pos_q != POS_MAX)
				pos_q <= pos_q + LEN_W'(1);
			if (body_hit) begin
				if (active)
					sub_q <= made ? 2'd0 : sub_q + 2'd1;
				if (k_next >= rb_q) begin
					rbc_q <= '0;
					sub_q <= '0;
					row_q <= row_next;
					if ({{(32-DIM_W){1'b0}}, row_next} >= height_q)
						phase_q <= PH_DONE;
				end else begin
					rbc_q <= k_next;
				end
			end
		end
	end

	// result register
	assign taken = vld_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else if ((body_hit && made) || cmd.load_stat)
			vld_q <= 1'b1;
		else if (taken)
			vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (body_hit && made) begin
			is_pixel  <= 1'b1;
			red       <= r_c;
			green     <= g_c;
			blue      <= b_c;
			alpha     <= a_c;
			status    <= ST_OK;
			final_res <= 1'b0;
		end else if (cmd.load_stat) begin
			is_pixel  <= 1'b0;
			red       <= 8'd0;
			green     <= 8'd0;
			blue      <= 8'd0;
			alpha     <= 8'd0;
			status    <= stat_c;
			final_res <= 1'b1;
		end
	end

	assign out_valid = vld_q;

	`BSPD_ASSERT(a_rearm, cmd.load_stat |=> (phase_q == PH_HEADER && pos_q == '0), "rearm missed")
	`BSPD_ASSERT(a_body_clean, (phase_q == PH_BODY) |-> (err_q == ST_OK), "body with error")
	`BSPD_ASSERT(a_out_hold, (vld_q && out_stall) |=> (vld_q && $stable(status)), "beat changed")

endmodule

>>> hdl/bspd_ctrl.sv
// ----------------------------------------------------------------------------
// BMP stream decoder controller
// Sequences byte intake, the header check steps and the closing status beat.
// ----------------------------------------------------------------------------
`include "bmp_stream_pixel_decoder_defines.svh"

module bspd_ctrl import bspd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     end_of_file,
	output logic     in_stall,
	input  dp_sts_t  sts,
	output ctl_cmd_t cmd
);

	localparam logic [2:0] S_RUN  = 3'd0;
	localparam logic [2:0] S_C1   = 3'd1;
	localparam logic [2:0] S_C2   = 3'd2;
	localparam logic [2:0] S_C3   = 3'd3;
	localparam logic [2:0] S_CM   = 3'd4;
	localparam logic [2:0] S_STAT = 3'd5;

	logic [2:0] state_q, state_d;
	logic       eof_q;

	assign in_stall      = state_q != S_RUN || sts.out_busy;
	assign cmd.accept    = in_valid && !in_stall;
	assign cmd.chk1      = state_q == S_C1;
	assign cmd.chk2      = state_q == S_C2;
	assign cmd.chk3      = state_q == S_C3;
	assign cmd.chkm      = state_q == S_CM;
	assign cmd.load_stat = state_q == S_STAT && !sts.out_busy;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_RUN: begin
				if (cmd.accept) begin
					if (sts.at_basic)
						state_d = S_C1;
					else if (sts.at_mask)
						state_d = S_CM;
					else if (end_of_file)
						state_d = S_STAT;
				end
			end
			S_C1: state_d = S_C2;
			S_C2: state_d = S_C3;
			S_C3: state_d = eof_q ? S_STAT : S_RUN;
			S_CM: state_d = eof_q ? S_STAT : S_RUN;
			S_STAT: begin
				if (!sts.out_busy)
					state_d = S_RUN;
			end
			default: state_d = S_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RUN;
			eof_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			// hold the end mark across the check steps
			if (cmd.accept)
				eof_q <= end_of_file;
		end
	end

	`BSPD_ASSERT_ALWAYS(a_cmd_excl, $onehot0({cmd.accept, cmd.chk1, cmd.chk2, cmd.chk3, cmd.chkm, cmd.load_stat}), "command overlap")
	`BSPD_ASSERT(a_chk_seq, (state_q == S_C1) |=> (state_q == S_C2), "check step skipped")
	`BSPD_ASSERT(a_eof_stat, (cmd.accept && end_of_file && !sts.at_basic && !sts.at_mask) |=> (state_q == S_STAT), "status beat missed")

endmodule

>>> hdl/bmp_stream_pixel_decoder.sv
// ----------------------------------------------------------------------------
// BMP stream pixel decoder
// One file byte per beat in; RGBA pixels and one closing status beat out.
// Throughput: one byte per cycle, except while the header checks after bytes 53 and 69 or a stalled result hold intake.
// A pixel is registered and shows in the cycle after its last byte; the status beat is loaded
// in S_STAT once the output is free, after the header checks if the end falls on byte 53 or 69.
// The end-of-file status holds intake in S_STAT before the next file starts.
// Reset (arst_n low) clears file_length, position, phase and the result valid.
// ----------------------------------------------------------------------------
module bmp_stream_pixel_decoder import bspd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [LEN_W-1:0] cfg_wr_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       file_byte,
	input  logic             end_of_file,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             is_pixel,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic [7:0]       alpha,
	output logic [4:0]       status,
	output logic             final_res
);

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	bspd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.end_of_file (end_of_file),
		.in_stall    (in_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	bspd_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.file_byte   (file_byte),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.is_pixel    (is_pixel),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.alpha       (alpha),
		.status      (status),
		.final_res   (final_res)
	);

endmodule
